// ===== design/kmmh_pkg.sv =====
// Shared types and constants for the keyed min/max history unit.
`default_nettype none

package kmmh_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [31:0]        sensor_id;
    logic signed [31:0] reading;
    logic signed [31:0] given_min;
    logic signed [31:0] given_max;
  } req_t;

  typedef struct packed {
    logic               tracked;
    logic signed [31:0] min_out;
    logic signed [31:0] max_out;
  } rsp_t;

  // Lookup token walking down the cell row.
  typedef struct packed {
    logic               valid;
    logic               done;      // matched or appended somewhere upstream
    logic               appended;
    logic [31:0]        sensor_id;
    logic signed [31:0] reading;
    logic signed [31:0] given_min;
    logic signed [31:0] given_max;
    logic signed [31:0] min_val;
    logic signed [31:0] max_val;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

// ===== design/kmmh_cell.sv =====
// One table entry: id, running min and max, and one stage of the lookup token path.
`default_nettype none

module kmmh_cell
  import kmmh_pkg::*;
#(
  parameter int INDEX  = 0,
  parameter int USED_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [USED_W-1:0] used,
  input  wire tok_t              tok_in,
  output tok_t                   tok_out
);

  logic [31:0]        ent_id;
  logic signed [31:0] ent_min;
  logic signed [31:0] ent_max;

  logic               is_live;
  logic               is_tail;
  logic               hit;
  logic               fill;
  logic signed [31:0] min_next;
  logic signed [31:0] max_next;
  tok_t               tok_next;

  always_comb begin
    is_live  = used > USED_W'(INDEX);
    is_tail  = used == USED_W'(INDEX);
    hit      = tok_in.valid && !tok_in.done && is_live && (ent_id == tok_in.sensor_id);
    // first unused entry takes a new id that found no match upstream
    fill     = tok_in.valid && !tok_in.done && is_tail;
    min_next = (tok_in.reading < ent_min) ? tok_in.reading : ent_min;
    max_next = (ent_max < tok_in.reading) ? tok_in.reading : ent_max;

    tok_next = tok_in;
    if (hit) begin
      tok_next.done    = 1'b1;
      tok_next.min_val = min_next;
      tok_next.max_val = max_next;
    end else if (fill) begin
      tok_next.done     = 1'b1;
      tok_next.appended = 1'b1;
      tok_next.min_val  = tok_in.reading;
      tok_next.max_val  = tok_in.reading;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      ent_min <= min_next;
      ent_max <= max_next;
    end else if (fill) begin
      ent_id  <= tok_in.sensor_id;
      ent_min <= tok_in.reading;
      ent_max <= tok_in.reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/keyed_min_max_history_unit.sv =====
// Top level of the keyed min/max history unit: control, entry count, result stage, cell row.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------
//  request | req_valid  | req_stall  | req  (action, sensor_id, reading, given_min/max)
//  result  | rsp_valid  | rsp_stall  | rsp  (tracked, min_out, max_out)
//
// A sample transaction walks the row of TABLE_DEPTH cells one cell per cycle; its result
// is then registered in the result holding stage and moved into the output register.
// A clear transaction skips the cell row; its result is set in the result holding stage.
// One transaction is in flight at a time; the next is taken once the previous result has
// moved into the output register, even while rsp_stall holds it there. A stalled result
// that blocks that move delays the next request. Requests are stalled while rst is high.
// Reset empties the table (entry count to zero); no sweep.
`default_nettype none

module keyed_min_max_history_unit
  import kmmh_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  logic [USED_W-1:0] used;
  rsp_t              res;

  logic              accept;
  logic              inject;
  logic              rsp_load;
  tok_t              chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] chain_valid;
  tok_t              tok_last;

  assign tok_last = chain[TABLE_DEPTH];
  assign accept   = req_valid && !req_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == ACT_CLEAR) ? ST_HOLD : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_last.valid) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = 1'b1;
    rsp_load  = 1'b0;
    unique case (state)
      ST_IDLE:   req_stall = 1'b0;
      ST_SEARCH: req_stall = 1'b1;
      ST_HOLD:   rsp_load  = !rsp_valid || !rsp_stall;
      default:   req_stall = 1'b1;
    endcase
    if (rst) begin
      req_stall = 1'b1;
    end
    inject = accept && (req.action == ACT_SAMPLE);
  end

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = inject;
    chain[0].sensor_id = req.sensor_id;
    chain[0].reading   = req.reading;
    chain[0].given_min = req.given_min;
    chain[0].given_max = req.given_max;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kmmh_cell #(
      .INDEX  (i),
      .USED_W (USED_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .used    (used),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
    assign chain_valid[i] = chain[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (accept && (req.action == ACT_CLEAR)) begin
        used <= '0;
      end else if (tok_last.valid && tok_last.appended) begin
        used <= used + USED_W'(1);
      end
    end
  end

  // result holding stage
  always_ff @(posedge clk) begin
    if (accept && (req.action == ACT_CLEAR)) begin
      res <= '0;
    end else if (tok_last.valid) begin
      res.tracked <= tok_last.done;
      res.min_out <= tok_last.done ? tok_last.min_val : tok_last.given_min;
      res.max_out <= tok_last.done ? tok_last.max_val : tok_last.given_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one lookup token in the cell row");

  a_exit_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> state == ST_SEARCH)
    else $error("token left the row outside a search");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (tok_last.valid && tok_last.appended) |-> used < USED_W'(TABLE_DEPTH))
    else $error("entry appended to a full table");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_CLEAR) |=> used == '0)
    else $error("clear did not empty the table");

endmodule

`default_nettype wire
